### rtl/trrp_pkg.sv
// Package for the tagged row record parser: field widths, codes and the result type.
package trrp_pkg;

  localparam int DATA_W  = 8;
  localparam int KEY_W   = 32;
  localparam int INDEX_W = 32;
  localparam int INT_W   = 64;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 3;

  // Field tags as they appear in the byte stream.
  localparam logic [DATA_W-1:0] TAG_INTEGER = 8'd1;
  localparam logic [DATA_W-1:0] TAG_STRING  = 8'd2;
  localparam logic [DATA_W-1:0] TAG_BOOLEAN = 8'd3;
  localparam logic [DATA_W-1:0] TAG_DATE    = 8'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_INTEGER    = 3'd0,
    KIND_BOOLEAN    = 3'd1,
    KIND_TEXT       = 3'd2,
    KIND_EMPTY_TEXT = 3'd3,
    KIND_STATUS     = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_BAD_TAG  = 3'd2,
    ST_BAD_BOOL = 3'd3,
    ST_TRAIL    = 3'd4
  } status_t;

  typedef struct packed {
    kind_t                     result_kind;
    logic [INDEX_W-1:0]        field_index;
    logic                      is_date;
    logic signed [INT_W-1:0]   integer_value;
    logic                      boolean_value;
    logic [DATA_W-1:0]         text_byte;
    logic                      text_last;
    logic [KEY_W-1:0]          echoed_key;
    logic                      row_done;
    status_t                   row_status;
  } result_t;

endpackage

### rtl/trrp_in_if.sv
// Input channel interface: one record byte per transaction.
interface trrp_in_if
  import trrp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;
  logic [KEY_W-1:0]  row_key;

  modport source (output valid, output data_byte, output last_byte, output row_key,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input row_key,
                  output ready);
endinterface

### rtl/trrp_out_if.sv
// Result channel interface: one decoded value or record status per transaction.
interface trrp_out_if
  import trrp_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       result_kind;
  logic [INDEX_W-1:0]      field_index;
  logic                    is_date;
  logic signed [INT_W-1:0] integer_value;
  logic                    boolean_value;
  logic [DATA_W-1:0]       text_byte;
  logic                    text_last;
  logic [KEY_W-1:0]        echoed_key;
  logic                    row_done;
  logic [STAT_W-1:0]       row_status;

  modport source (output valid, output result_kind, output field_index, output is_date,
                  output integer_value, output boolean_value, output text_byte,
                  output text_last, output echoed_key, output row_done,
                  output row_status, input ready);
  modport sink   (input valid, input result_kind, input field_index, input is_date,
                  input integer_value, input boolean_value, input text_byte,
                  input text_last, input echoed_key, input row_done,
                  input row_status, output ready);
endinterface

### rtl/tagged_row_record_parser.sv
// Top level of the tagged row record parser.
//
//   channel   direction  payload
//   in_chan   sink       data_byte, last_byte, row_key
//   out_chan  source     result_kind, field_index, is_date, integer_value,
//                        boolean_value, text_byte, text_last, echoed_key,
//                        row_done, row_status
//
// One byte is taken per cycle unless stalled; its result, if any, is registered
// and offered in the next cycle. The input is taken whenever the result register
// is empty or is being drained in the same cycle, so a stall holds at most
// one result. Synchronous reset returns the parser to the start of a record.
module tagged_row_record_parser
  import trrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  trrp_in_if.sink     in_chan,
  trrp_out_if.source  out_chan
);

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_TAG,
    PH_INT,
    PH_BOOL,
    PH_LEN,
    PH_TEXT,
    PH_DONE
  } phase_t;

  phase_t              phase_r, phase_cur, phase_nxt;
  logic [2:0]          cnt_r, cnt_cur, cnt_nxt, cnt_inc;
  logic [INDEX_W-1:0]  exp_r, exp_cur, exp_nxt;
  logic [INDEX_W-1:0]  done_r, done_cur, done_nxt, done_inc;
  logic [INT_W-1:0]    asm_r, asm_cur, asm_nxt, asm_byte;
  logic [31:0]         rem_r, rem_nxt;
  logic [1:0]          tag_r, tag_cur, tag_nxt;
  logic [KEY_W-1:0]    key_r, key_cur;
  logic                disc_r, disc_cur, disc_nxt;
  status_t             err_r, err_cur, err_nxt, err_now;
  logic                start_r;
  logic                finish;
  logic                emit;
  logic                accept;
  logic                out_valid_r;
  result_t             res, res_r;
  logic [DATA_W-1:0]   b;

  assign b      = in_chan.data_byte;
  assign in_chan.ready = rst_n && (!out_valid_r || out_chan.ready);
  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    // A new record starts from cleared state, whatever the registers hold.
    phase_cur = start_r ? PH_COUNT : phase_r;
    cnt_cur   = start_r ? 3'd0 : cnt_r;
    exp_cur   = start_r ? '0 : exp_r;
    done_cur  = start_r ? '0 : done_r;
    asm_cur   = start_r ? '0 : asm_r;
    tag_cur   = start_r ? 2'd0 : tag_r;
    key_cur   = start_r ? in_chan.row_key : key_r;
    disc_cur  = start_r ? 1'b0 : disc_r;
    err_cur   = start_r ? ST_OK : err_r;

    phase_nxt = phase_cur;
    cnt_nxt   = cnt_cur;
    exp_nxt   = exp_cur;
    done_nxt  = done_cur;
    asm_nxt   = asm_cur;
    rem_nxt   = rem_r;
    tag_nxt   = tag_cur;
    disc_nxt  = disc_cur;
    err_nxt   = err_cur;
    err_now   = ST_OK;
    finish    = 1'b0;
    emit      = 1'b0;

    cnt_inc  = cnt_cur + 3'd1;
    done_inc = done_cur + 32'd1;
    asm_byte = asm_cur | ({{(INT_W-DATA_W){1'b0}}, b} << {cnt_cur, 3'b000});

    res             = '0;
    res.result_kind = KIND_STATUS;
    res.row_status  = ST_OK;
    res.echoed_key  = key_cur;

    if (!disc_cur) begin
      unique case (phase_cur)
        PH_COUNT: begin
          asm_nxt = asm_byte;
          cnt_nxt = cnt_inc;
          if (cnt_cur == 3'd3) begin
            exp_nxt   = asm_byte[INDEX_W-1:0];
            asm_nxt   = '0;
            cnt_nxt   = 3'd0;
            phase_nxt = (asm_byte[INDEX_W-1:0] == '0) ? PH_DONE : PH_TAG;
          end
        end
        PH_TAG: begin
          if (b == TAG_INTEGER || b == TAG_STRING || b == TAG_BOOLEAN || b == TAG_DATE) begin
            tag_nxt = b[1:0] - 2'd1;
            asm_nxt = '0;
            cnt_nxt = 3'd0;
            if (b == TAG_INTEGER) begin
              phase_nxt = PH_INT;
            end else if (b == TAG_BOOLEAN) begin
              phase_nxt = PH_BOOL;
            end else begin
              phase_nxt = PH_LEN;
            end
          end else begin
            err_now = ST_BAD_TAG;
          end
        end
        PH_INT: begin
          asm_nxt = asm_byte;
          cnt_nxt = cnt_inc;
          if (cnt_cur == 3'd7) begin
            emit              = 1'b1;
            res.result_kind   = KIND_INTEGER;
            res.field_index   = done_cur;
            res.integer_value = asm_byte;
            finish            = 1'b1;
          end
        end
        PH_BOOL: begin
          if (b > 8'd1) begin
            err_now = ST_BAD_BOOL;
          end else begin
            emit              = 1'b1;
            res.result_kind   = KIND_BOOLEAN;
            res.field_index   = done_cur;
            res.boolean_value = b[0];
            finish            = 1'b1;
          end
        end
        PH_LEN: begin
          asm_nxt = asm_byte;
          cnt_nxt = cnt_inc;
          if (cnt_cur == 3'd3) begin
            asm_nxt = '0;
            cnt_nxt = 3'd0;
            if (asm_byte[31:0] == 32'd0) begin
              emit            = 1'b1;
              res.result_kind = KIND_EMPTY_TEXT;
              res.field_index = done_cur;
              res.is_date     = (tag_cur == 2'd3);
              finish          = 1'b1;
            end else begin
              rem_nxt   = asm_byte[31:0];
              phase_nxt = PH_TEXT;
            end
          end
        end
        PH_TEXT: begin
          emit            = 1'b1;
          res.result_kind = KIND_TEXT;
          res.field_index = done_cur;
          res.is_date     = (tag_cur == 2'd3);
          res.text_byte   = b;
          rem_nxt         = rem_r - 32'd1;
          if (rem_r == 32'd1) begin
            res.text_last = 1'b1;
            finish        = 1'b1;
          end
        end
        default: begin
          err_now = ST_TRAIL;
        end
      endcase
    end

    if (finish) begin
      done_nxt  = done_inc;
      phase_nxt = (done_inc == exp_cur) ? PH_DONE : PH_TAG;
      asm_nxt   = '0;
      cnt_nxt   = 3'd0;
    end

    if (err_now != ST_OK) begin
      disc_nxt = 1'b1;
      err_nxt  = err_now;
    end

    if (in_chan.last_byte) begin
      emit         = 1'b1;
      res.row_done = 1'b1;
      if (disc_nxt) begin
        res.row_status = err_nxt;
      end else begin
        res.row_status = (phase_nxt == PH_DONE) ? ST_OK : ST_TRUNC;
      end
      disc_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_COUNT;
      cnt_r       <= 3'd0;
      exp_r       <= '0;
      done_r      <= '0;
      asm_r       <= '0;
      rem_r       <= '0;
      tag_r       <= 2'd0;
      key_r       <= '0;
      disc_r      <= 1'b0;
      err_r       <= ST_OK;
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        exp_r       <= exp_nxt;
        done_r      <= done_nxt;
        asm_r       <= asm_nxt;
        rem_r       <= rem_nxt;
        tag_r       <= tag_nxt;
        key_r       <= key_cur;
        disc_r      <= disc_nxt;
        err_r       <= err_nxt;
        start_r     <= in_chan.last_byte;
        out_valid_r <= emit;
        if (emit) begin
          res_r <= res;
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_kind   = res_r.result_kind;
  assign out_chan.field_index   = res_r.field_index;
  assign out_chan.is_date       = res_r.is_date;
  assign out_chan.integer_value = res_r.integer_value;
  assign out_chan.boolean_value = res_r.boolean_value;
  assign out_chan.text_byte     = res_r.text_byte;
  assign out_chan.text_last     = res_r.text_last;
  assign out_chan.echoed_key    = res_r.echoed_key;
  assign out_chan.row_done      = res_r.row_done;
  assign out_chan.row_status    = res_r.row_status;

endmodule

### rtl/trrp_checker.sv
// Port-level checks for the tagged row record parser, bound to the top level.
module trrp_checker
  import trrp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic              out_done,
  input logic [STAT_W-1:0] out_status,
  input logic              out_text_last
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // The last byte of a record always yields a result that closes the record.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> out_valid && out_done)
    else $error("record end did not produce a closing result");

  // A status-only transaction exists only to close a record.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_STATUS) |-> out_done)
    else $error("status-only result without record end");

  // Status is reported only on the closing transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done |-> (out_status == ST_OK))
    else $error("status set on a transaction that does not end the record");

  // Only text bytes carry the end-of-text mark.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_last |-> (out_kind == KIND_TEXT))
    else $error("text end mark on a non-text result");

endmodule

bind tagged_row_record_parser trrp_checker u_trrp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_last       (in_chan.last_byte),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_kind      (out_chan.result_kind),
  .out_done      (out_chan.row_done),
  .out_status    (out_chan.row_status),
  .out_text_last (out_chan.text_last)
);

### sim/tb_tagged_row_record_parser.sv
// Self-checking testbench for the tagged row record parser: directed records, then random ones.
module tb_tagged_row_record_parser;
  import trrp_pkg::*;

  localparam int          RANDOM_BYTES = 1250;
  localparam int          CYCLE_LIMIT  = 500_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [31:0] KEY_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] KEY_ZERO     = 32'h0000_0000;
  localparam logic [31:0] KEY_MIXED    = 32'h5A5A_A5A5;

  typedef enum logic [2:0] {
    AT_COUNT, AT_TAG, AT_INT, AT_BOOL, AT_LEN, AT_TEXT, AT_END
  } phase_t;

  // One byte of stimulus; when typed is set, the listed fields are the expected result.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] key;
    logic        typed;
    kind_t       kind;
    logic [31:0] index;
    logic [63:0] ival;
    logic        bval;
    logic        done;
    status_t     status;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  trrp_in_if  in_chan ();
  trrp_out_if out_chan ();

  tagged_row_record_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #4 clk = ~clk;

  // Parser state mirrored by the testbench.
  phase_t      rec_phase     = AT_COUNT;
  int unsigned byte_pos      = 0;
  logic [31:0] fields_wanted = '0;
  logic [31:0] fields_seen   = '0;
  logic [63:0] shift_acc     = '0;
  logic [31:0] text_left     = '0;
  logic [7:0]  cur_tag       = '0;
  logic [31:0] rec_key       = '0;
  bit          skipping      = 1'b0;
  status_t     pending_err   = ST_OK;
  bit          new_record    = 1'b1;

  result_t     expected_results[$];
  stim_row_t   typed_row;
  stim_row_t   directed_rows[30];
  bit          in_quiet  = 1'b0;
  bit          out_quiet = 1'b0;
  int          failures       = 0;
  int          bytes_sent     = 0;
  int          records_sent   = 0;
  int          results_seen   = 0;
  int          rows_closed    = 0;
  int          rows_in_error  = 0;
  int          cycle_count    = 0;

  function automatic void close_field();
    fields_seen = fields_seen + 1;
    rec_phase   = (fields_seen == fields_wanted) ? AT_END : AT_TAG;
    shift_acc   = '0;
    byte_pos    = 0;
  endfunction

  // Advances the mirrored parser by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     input logic [31:0] key, output result_t r);
    bit          emit;
    bit          has_err;
    status_t     err;
    logic [31:0] len;
    emit    = 1'b0;
    has_err = 1'b0;
    err     = ST_OK;
    r       = '0;
    r.result_kind = KIND_STATUS;
    r.row_status  = ST_OK;
    if (new_record) begin
      rec_phase     = AT_COUNT;
      byte_pos      = 0;
      fields_wanted = '0;
      fields_seen   = '0;
      shift_acc     = '0;
      text_left     = '0;
      cur_tag       = '0;
      skipping      = 1'b0;
      pending_err   = ST_OK;
      rec_key       = key;
      new_record    = 1'b0;
    end
    if (!skipping) begin
      case (rec_phase)
        AT_COUNT: begin
          shift_acc[8*byte_pos +: 8] = b;
          byte_pos++;
          if (byte_pos == 4) begin
            fields_wanted = shift_acc[31:0];
            shift_acc     = '0;
            byte_pos      = 0;
            rec_phase     = (fields_wanted == 0) ? AT_END : AT_TAG;
          end
        end
        AT_TAG: begin
          if (b >= TAG_INTEGER && b <= TAG_DATE) begin
            cur_tag   = b;
            shift_acc = '0;
            byte_pos  = 0;
            rec_phase = (b == TAG_INTEGER) ? AT_INT : (b == TAG_BOOLEAN) ? AT_BOOL : AT_LEN;
          end else begin
            has_err = 1'b1;
            err     = ST_BAD_TAG;
          end
        end
        AT_INT: begin
          shift_acc[8*byte_pos +: 8] = b;
          byte_pos++;
          if (byte_pos == 8) begin
            emit            = 1'b1;
            r.result_kind   = KIND_INTEGER;
            r.field_index   = fields_seen;
            r.integer_value = shift_acc;
            close_field();
          end
        end
        AT_BOOL: begin
          if (b > 8'd1) begin
            has_err = 1'b1;
            err     = ST_BAD_BOOL;
          end else begin
            emit            = 1'b1;
            r.result_kind   = KIND_BOOLEAN;
            r.field_index   = fields_seen;
            r.boolean_value = b[0];
            close_field();
          end
        end
        AT_LEN: begin
          shift_acc[8*byte_pos +: 8] = b;
          byte_pos++;
          if (byte_pos == 4) begin
            len       = shift_acc[31:0];
            shift_acc = '0;
            byte_pos  = 0;
            if (len == 0) begin
              emit          = 1'b1;
              r.result_kind = KIND_EMPTY_TEXT;
              r.field_index = fields_seen;
              r.is_date     = (cur_tag == TAG_DATE);
              close_field();
            end else begin
              text_left = len;
              rec_phase = AT_TEXT;
            end
          end
        end
        AT_TEXT: begin
          emit          = 1'b1;
          r.result_kind = KIND_TEXT;
          r.field_index = fields_seen;
          r.is_date     = (cur_tag == TAG_DATE);
          r.text_byte   = b;
          text_left     = text_left - 1;
          if (text_left == 0) begin
            r.text_last = 1'b1;
            close_field();
          end
        end
        default: begin
          has_err = 1'b1;
          err     = ST_TRAIL;
        end
      endcase
      if (has_err) begin
        skipping    = 1'b1;
        pending_err = err;
      end
    end
    if (last) begin
      emit         = 1'b1;
      r.row_done   = 1'b1;
      r.row_status = skipping ? pending_err : (rec_phase == AT_END) ? ST_OK : ST_TRUNC;
      new_record   = 1'b1;
      skipping     = 1'b0;
    end
    r.echoed_key = rec_key;
    return emit;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf({"kind=%0d idx=%0d date=%b int=%0d bool=%b text=%02h last=%b ",
                      "key=%08h done=%b status=%0d"},
                     r.result_kind, r.field_index, r.is_date, r.integer_value,
                     r.boolean_value, r.text_byte, r.text_last, r.echoed_key,
                     r.row_done, r.row_status);
  endfunction

  function automatic stim_row_t plain(input logic [7:0] data, input logic last,
                                      input logic [31:0] key);
    stim_row_t row;
    row        = '0;
    row.data   = data;
    row.last   = last;
    row.key    = key;
    row.kind   = KIND_STATUS;
    row.status = ST_OK;
    return row;
  endfunction

  function automatic stim_row_t checked_row(input logic [7:0] data, input logic last,
                                            input logic [31:0] key, input kind_t kind,
                                            input logic [31:0] index,
                                            input logic [63:0] ival, input logic bval,
                                            input status_t status);
    stim_row_t row;
    row        = plain(data, last, key);
    row.typed  = 1'b1;
    row.kind   = kind;
    row.index  = index;
    row.ival   = ival;
    row.bval   = bval;
    row.done   = last;
    row.status = status;
    return row;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Prediction on every input transaction, then checking of every result transaction.
  always @(posedge clk) begin
    result_t pred;
    result_t want;
    result_t got;
    bit      has;
    if (rst_n && in_chan.valid === 1'b1 && in_chan.ready === 1'b1) begin
      has = decode_byte(in_chan.data_byte, in_chan.last_byte, in_chan.row_key, pred);
      if (typed_row.typed) begin
        has                  = 1'b1;
        pred.result_kind     = typed_row.kind;
        pred.field_index     = typed_row.index;
        pred.integer_value   = typed_row.ival;
        pred.boolean_value   = typed_row.bval;
        pred.row_done        = typed_row.done;
        pred.row_status      = typed_row.status;
      end
      if (has) expected_results.insert(expected_results.size(), pred);
    end
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.result_kind   = kind_t'(out_chan.result_kind);
      got.field_index   = out_chan.field_index;
      got.is_date       = out_chan.is_date;
      got.integer_value = out_chan.integer_value;
      got.boolean_value = out_chan.boolean_value;
      got.text_byte     = out_chan.text_byte;
      got.text_last     = out_chan.text_last;
      got.echoed_key    = out_chan.echoed_key;
      got.row_done      = out_chan.row_done;
      got.row_status    = status_t'(out_chan.row_status);
      results_seen++;
      if (expected_results.size() == 0) begin
        if (failures < 10) $display("Unexpected result: %s", fmt_result(got));
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (want.row_done) begin
          rows_closed++;
          if (want.row_status != ST_OK) rows_in_error++;
        end
        if (got !== want) begin
          if (failures < 10) begin
            $display("Result mismatch at cycle %0d", cycle_count);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
          failures++;
        end
      end
    end
  end

  // Result side: stalls a random number of cycles before taking each transaction.
  initial begin
    int unsigned stall;
    out_chan.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        out_chan.ready <= 1'b0;
        @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input stim_row_t row);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= row.data;
    in_chan.last_byte <= row.last;
    in_chan.row_key   <= row.key;
    typed_row         <= row;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    @(negedge clk);
    bytes_sent++;
    if (row.last) records_sent++;
  endtask

  task automatic run_random_record();
    logic [7:0]  bytes[$];
    int          tag_at[$];
    int          bool_at[$];
    int unsigned nfields;
    int unsigned mode;
    int unsigned len;
    int unsigned cut;
    logic [31:0] key;
    logic [31:0] count;
    logic [63:0] v;
    logic [7:0]  tag;
    mode    = $urandom_range(0, 19);
    key     = $urandom;
    nfields = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
    count   = (mode == 19) ? $urandom : nfields;
    for (int i = 0; i < 4; i++) bytes.insert(bytes.size(), count[8*i +: 8]);
    for (int f = 0; f < nfields; f++) begin
      tag = 8'($urandom_range(TAG_INTEGER, TAG_DATE));
      tag_at.insert(tag_at.size(), bytes.size());
      bytes.insert(bytes.size(), tag);
      case (tag)
        TAG_INTEGER: begin
          case ($urandom_range(0, 5))
            0:       v = 64'h8000_0000_0000_0000;
            1:       v = 64'h7FFF_FFFF_FFFF_FFFF;
            2:       v = '1;
            3:       v = '0;
            default: v = {$urandom, $urandom};
          endcase
          for (int i = 0; i < 8; i++) bytes.insert(bytes.size(), v[8*i +: 8]);
        end
        TAG_BOOLEAN: begin
          bool_at.insert(bool_at.size(), bytes.size());
          bytes.insert(bytes.size(), 8'($urandom_range(0, 1)));
        end
        default: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
          for (int i = 0; i < 4; i++) bytes.insert(bytes.size(), len[8*i +: 8]);
          repeat (len) bytes.insert(bytes.size(), 8'($urandom));
        end
      endcase
    end
    // Most records stay well formed; the rest are broken in one of several ways.
    case (mode)
      13: begin
        bytes.delete();
        repeat ($urandom_range(1, 12)) bytes.insert(bytes.size(), 8'($urandom));
      end
      14: repeat ($urandom_range(1, 3)) bytes.insert(bytes.size(), 8'($urandom));
      15, 16: begin
        cut = $urandom_range(1, bytes.size() - 1);
        while (bytes.size() > cut) void'(bytes.pop_back());
      end
      17: begin
        if (tag_at.size() > 0)
          bytes[tag_at[$urandom_range(0, tag_at.size() - 1)]] =
              ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(5, 255));
        else
          bytes.insert(bytes.size(), 8'($urandom));
      end
      18: begin
        if (bool_at.size() > 0)
          bytes[bool_at[$urandom_range(0, bool_at.size() - 1)]] = 8'($urandom_range(2, 255));
        else
          bytes.insert(bytes.size(), 8'($urandom));
      end
      default: ;
    endcase
    // Only the first byte's key counts, so later bytes carry noise in that field.
    for (int i = 0; i < bytes.size(); i++)
      send_byte(plain(bytes[i], i == bytes.size() - 1, (i == 0) ? key : $urandom));
  endtask

  initial begin
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= '0;
    in_chan.last_byte <= 1'b0;
    in_chan.row_key   <= '0;
    typed_row         <= '0;
    directed_rows = '{
      // Zero field count, then a byte past the end arriving as the last one.
      plain(8'h00, 1'b0, KEY_ALL_ONES),
      plain(8'h00, 1'b0, KEY_ALL_ONES),
      plain(8'h00, 1'b0, KEY_ALL_ONES),
      plain(8'h00, 1'b0, KEY_ALL_ONES),
      checked_row(8'hFF, 1'b1, KEY_ALL_ONES, KIND_STATUS, 32'd0, 64'd0, 1'b0, ST_TRAIL),
      // Three fields: true, an empty date, then an unknown tag on the last byte.
      plain(8'h03, 1'b0, KEY_ZERO),
      plain(8'h00, 1'b0, KEY_ZERO),
      plain(8'h00, 1'b0, KEY_ZERO),
      plain(8'h00, 1'b0, KEY_ZERO),
      plain(TAG_BOOLEAN, 1'b0, KEY_ZERO),
      checked_row(8'h01, 1'b0, KEY_ZERO, KIND_BOOLEAN, 32'd0, 64'd0, 1'b1, ST_OK),
      plain(TAG_DATE, 1'b0, KEY_ZERO),
      plain(8'h00, 1'b0, KEY_ZERO),
      plain(8'h00, 1'b0, KEY_ZERO),
      plain(8'h00, 1'b0, KEY_ZERO),
      plain(8'h00, 1'b0, KEY_ZERO),
      checked_row(8'hFF, 1'b1, KEY_ZERO, KIND_STATUS, 32'd0, 64'd0, 1'b0, ST_BAD_TAG),
      // One integer field holding the most negative value, ending with the record.
      plain(8'h01, 1'b0, KEY_MIXED),
      plain(8'h00, 1'b0, KEY_MIXED),
      plain(8'h00, 1'b0, KEY_MIXED),
      plain(8'h00, 1'b0, KEY_MIXED),
      plain(TAG_INTEGER, 1'b0, KEY_MIXED),
      plain(8'h00, 1'b0, KEY_MIXED),
      plain(8'h00, 1'b0, KEY_MIXED),
      plain(8'h00, 1'b0, KEY_MIXED),
      plain(8'h00, 1'b0, KEY_MIXED),
      plain(8'h00, 1'b0, KEY_MIXED),
      plain(8'h00, 1'b0, KEY_MIXED),
      plain(8'h00, 1'b0, KEY_MIXED),
      checked_row(8'h80, 1'b1, KEY_MIXED, KIND_INTEGER, 32'd0, 64'h8000_0000_0000_0000,
                  1'b0, ST_OK)
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) send_byte(directed_rows[i]);
    while (bytes_sent < RANDOM_BYTES + $size(directed_rows)) begin
      if ($urandom_range(0, 7) == 0) in_quiet = !in_quiet;
      run_random_record();
    end
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Fed %0d bytes in %0d records and checked %0d results.",
             bytes_sent, records_sent, results_seen);
    $display("Records closed: %0d, of which %0d ended with a bad status.",
             rows_closed, rows_in_error);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures", failures);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### tagged_row_record_parser.f
rtl/trrp_pkg.sv
rtl/trrp_in_if.sv
rtl/trrp_out_if.sv
rtl/tagged_row_record_parser.sv
rtl/trrp_checker.sv
sim/tb_tagged_row_record_parser.sv
